[hdl/boxf_pkg.sv]
`timescale 1ns / 1ps
package boxf_pkg;

   // Field and register widths
   localparam int COL_BITS      = 9;
   localparam int ROW_BITS      = 13;
   localparam int OUT_X_BITS    = 8;
   localparam int OUT_Y_BITS    = 12;
   localparam int MEAN_BITS     = 16;
   localparam int PIXEL_IN_BITS = 16;
   localparam int CSR_ADDR_BITS = 1;
   localparam int CSR_DATA_BITS = 13;

   // Frame height limit
   localparam logic [ROW_BITS-1:0] HEIGHT_MAX = 13'd4096;

   // Register reset values
   localparam logic [COL_BITS-1:0] WIDTH_RESET  = 9'd256;
   localparam logic [ROW_BITS-1:0] HEIGHT_RESET = 13'd256;

   // Register indexes
   localparam logic [CSR_ADDR_BITS-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_FRAME_HEIGHT = 1'b1;

   // Job queue between front and back
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // Position and neighbor validity of one output pixel
   typedef struct packed {
      logic [OUT_X_BITS-1:0] out_x;
      logic [OUT_Y_BITS-1:0] out_y;
      logic                  frame_end;
      logic                  row_lo_ok;
      logic                  row_hi_ok;
      logic                  col_lo_ok;
      logic                  col_hi_ok;
   } job_ctl_type;

endpackage

[hdl/boxf_ram.sv]
`timescale 1ns / 1ps
module boxf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read-first registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/boxf_front.sv]
`timescale 1ns / 1ps
module boxf_front #(
   parameter int MAX_WIDTH  = 256,
   parameter int STORE_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic                                     req_tuser,
   input  logic [boxf_pkg::PIXEL_IN_BITS-1:0]       req_tdata,
   input  logic                                     csr_we,
   input  logic [boxf_pkg::CSR_ADDR_BITS-1:0]       csr_addr,
   input  logic [boxf_pkg::CSR_DATA_BITS-1:0]       csr_wdata,
   input  logic [boxf_pkg::QUEUE_CNT_BITS-1:0]      q_count,
   output logic                                     push,
   output logic [8:0][STORE_BITS-1:0]               push_win,
   output boxf_pkg::job_ctl_type                    push_ctl
);

   localparam int ADDR_BITS = $clog2(MAX_WIDTH);
   localparam int CB = boxf_pkg::COL_BITS;
   localparam int RB = boxf_pkg::ROW_BITS;
   localparam int YB = boxf_pkg::OUT_Y_BITS;

   logic [CB-1:0] width_reg_ff, height_unused;
   logic [RB-1:0] height_reg_ff;
   logic [CB-1:0] eff_w;
   logic [RB-1:0] eff_h;

   logic [CB-1:0] in_col_ff, in_col_in;
   logic [RB-1:0] in_row_ff, in_row_in;
   logic [CB-1:0] out_col_ff, out_col_in;
   logic [YB-1:0] out_row_ff, out_row_in;

   logic req_fire, drain, take, emit, last;
   logic [ADDR_BITS-1:0] addr;
   boxf_pkg::job_ctl_type ctl;

   logic                   s1_valid_ff, s1_drain_ff, s1_emit_ff;
   logic [STORE_BITS-1:0]  s1_bot_ff;
   logic [ADDR_BITS-1:0]   s1_addr_ff;
   boxf_pkg::job_ctl_type  s1_ctl_ff;

   logic [STORE_BITS-1:0]  rd_a, rd_b;
   logic [8:0][STORE_BITS-1:0] win_ff, win_in;

   assign height_unused = '0;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_reg_ff  <= boxf_pkg::WIDTH_RESET;
         height_reg_ff <= boxf_pkg::HEIGHT_RESET;
      end else if (csr_we) begin
         if (csr_addr == boxf_pkg::CSR_FRAME_WIDTH) begin
            width_reg_ff <= csr_wdata[CB-1:0];
         end
         if (csr_addr == boxf_pkg::CSR_FRAME_HEIGHT) begin
            height_reg_ff <= csr_wdata;
         end
      end
   end

   // Clamp frame size to the supported range
   always_comb begin
      eff_w = width_reg_ff;
      if (width_reg_ff < CB'(2)) begin
         eff_w = CB'(2);
      end else if (32'(width_reg_ff) > MAX_WIDTH) begin
         eff_w = CB'(MAX_WIDTH);
      end
      eff_h = height_reg_ff;
      if (height_reg_ff < RB'(2)) begin
         eff_h = RB'(2);
      end else if (height_reg_ff > boxf_pkg::HEIGHT_MAX) begin
         eff_h = boxf_pkg::HEIGHT_MAX;
      end
   end

   // Classify the incoming item
   assign req_tready = (32'(q_count) + 32'(s1_valid_ff)) < boxf_pkg::QUEUE_DEPTH;
   assign req_fire   = req_tvalid && req_tready;
   assign drain      = (in_row_ff >= eff_h);
   assign take       = req_fire && !(req_tuser && !drain);
   assign emit       = (in_row_ff >= RB'(2)) || ((in_row_ff == RB'(1)) && (in_col_ff != '0));
   assign last       = emit && (({1'b0, out_col_ff} + 10'd1) >= {1'b0, eff_w})
                       && (({1'b0, out_row_ff} + 13'd1) >= eff_h);
   assign addr       = ADDR_BITS'(in_col_ff);

   // Output pixel position and which neighbors lie inside the image
   always_comb begin
      ctl.out_x     = out_col_ff[boxf_pkg::OUT_X_BITS-1:0];
      ctl.out_y     = out_row_ff;
      ctl.frame_end = last;
      ctl.row_lo_ok = (out_row_ff != '0);
      ctl.row_hi_ok = (({1'b0, out_row_ff} + 13'd1) < eff_h);
      ctl.col_lo_ok = (out_col_ff != '0);
      ctl.col_hi_ok = (({1'b0, out_col_ff} + 10'd1) < {1'b0, eff_w});
   end

   // Advance input and output positions
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (csr_we || (take && last)) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (take) begin
         if (({1'b0, in_col_ff} + 10'd1) >= {1'b0, eff_w}) begin
            in_col_in = '0;
            in_row_in = in_row_ff + RB'(1);
         end else begin
            in_col_in = in_col_ff + CB'(1);
         end
         if (emit) begin
            if (({1'b0, out_col_ff} + 10'd1) >= {1'b0, eff_w}) begin
               out_col_in = '0;
               out_row_in = out_row_ff + YB'(1);
            end else begin
               out_col_in = out_col_ff + CB'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         s1_valid_ff <= take && !csr_we;
      end
   end

   // Hold the accepted item while the line stores are read
   always_ff @(posedge clock) begin
      s1_drain_ff <= drain;
      s1_emit_ff  <= emit;
      s1_bot_ff   <= drain ? '0 : req_tdata[STORE_BITS-1:0] | height_unused[0 +: 1] * '0;
      s1_addr_ff  <= addr;
      s1_ctl_ff   <= ctl;
   end

   // Latest row
   boxf_ram #(.WIDTH(STORE_BITS), .DEPTH(MAX_WIDTH)) u_store_a (
      .clock   (clock),
      .wr_en   (take && !drain),
      .wr_addr (addr),
      .wr_data (req_tdata[STORE_BITS-1:0]),
      .rd_addr (addr),
      .rd_data (rd_a)
   );

   // Row before, filled from the latest row once it has been read
   boxf_ram #(.WIDTH(STORE_BITS), .DEPTH(MAX_WIDTH)) u_store_b (
      .clock   (clock),
      .wr_en   (s1_valid_ff && !s1_drain_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (rd_a),
      .rd_addr (addr),
      .rd_data (rd_b)
   );

   // Shift the window by one column
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_in[r*3]     = win_ff[r*3 + 1];
         win_in[r*3 + 1] = win_ff[r*3 + 2];
      end
      win_in[2] = rd_b;
      win_in[5] = rd_a;
      win_in[8] = s1_bot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         win_ff <= '0;
      end else if (s1_valid_ff) begin
         if (s1_emit_ff && s1_ctl_ff.frame_end) begin
            win_ff <= '0;
         end else begin
            win_ff <= win_in;
         end
      end
   end

   // Hand the job to the back part
   assign push     = s1_valid_ff && s1_emit_ff;
   assign push_win = win_in;
   assign push_ctl = s1_ctl_ff;

endmodule

[hdl/boxf_queue.sv]
`timescale 1ns / 1ps
module boxf_queue #(
   parameter int DATA_BITS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  logic [DATA_BITS-1:0]                push_data,
   input  logic                                pop,
   output logic [DATA_BITS-1:0]                head_data,
   output logic                                not_empty,
   output logic [boxf_pkg::QUEUE_CNT_BITS-1:0] count
);

   localparam int PB = boxf_pkg::QUEUE_PTR_BITS;
   localparam int NB = boxf_pkg::QUEUE_CNT_BITS;

   logic [DATA_BITS-1:0] slot_ff [boxf_pkg::QUEUE_DEPTH];
   logic [PB-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [NB-1:0] count_ff;

   function automatic logic [PB-1:0] next_ptr(input logic [PB-1:0] ptr);
      next_ptr = (ptr == PB'(boxf_pkg::QUEUE_DEPTH - 1)) ? '0 : ptr + PB'(1);
   endfunction

   // Store pushed jobs
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Track pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + NB'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - NB'(1);
         end
      end
   end

   assign head_data = slot_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

endmodule

[hdl/boxf_back.sv]
`timescale 1ns / 1ps
module boxf_back #(
   parameter int STORE_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 q_valid,
   input  logic [8:0][STORE_BITS-1:0]           q_win,
   input  boxf_pkg::job_ctl_type                q_ctl,
   output logic                                 pop,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [boxf_pkg::MEAN_BITS-1:0]       rsp_mean,
   output logic [boxf_pkg::OUT_X_BITS-1:0]      rsp_x,
   output logic [boxf_pkg::OUT_Y_BITS-1:0]      rsp_y,
   output logic                                 rsp_last
);

   // Sum of up to nine pixels, and reciprocal constants for n in {4, 6, 9}:
   // floor(v / n) == (v * ceil(2^SHIFT / n)) >> SHIFT for every v below 2^ACC_BITS.
   localparam int ACC_BITS  = STORE_BITS + 4;
   localparam int SHIFT     = ACC_BITS + 4;
   localparam int MAG_BITS  = ACC_BITS + 3;
   localparam int PROD_BITS = ACC_BITS + MAG_BITS;
   localparam logic [MAG_BITS-1:0] MAG_4 = MAG_BITS'(64'd1 << (SHIFT - 2));
   localparam logic [MAG_BITS-1:0] MAG_6 = MAG_BITS'(((64'd1 << SHIFT) + 64'd5) / 64'd6);
   localparam logic [MAG_BITS-1:0] MAG_9 = MAG_BITS'(((64'd1 << SHIFT) + 64'd8) / 64'd9);

   logic advance;
   logic [2:0] row_ok, col_ok;
   logic [2:0][ACC_BITS-1:0] row_sum;
   logic [ACC_BITS-1:0] acc;
   logic [ACC_BITS-1:0] round_add;
   logic [MAG_BITS-1:0] mag;

   logic                  b1_valid_ff;
   logic [ACC_BITS-1:0]   b1_v_ff;
   logic [MAG_BITS-1:0]   b1_mag_ff;
   boxf_pkg::job_ctl_type b1_ctl_ff;

   logic                  b2_valid_ff;
   logic [PROD_BITS-1:0]  b2_prod_ff, prod;
   boxf_pkg::job_ctl_type b2_ctl_ff;

   logic                                 rsp_valid_ff;
   logic [boxf_pkg::MEAN_BITS-1:0]       mean_ff;
   logic [boxf_pkg::OUT_X_BITS-1:0]      x_ff;
   logic [boxf_pkg::OUT_Y_BITS-1:0]      y_ff;
   logic                                 last_ff;

   // Move the whole pipeline unless the result register is stalled
   assign advance = !rsp_valid_ff || rsp_tready;
   assign pop     = advance && q_valid;

   // Sum the neighbors inside the image
   assign row_ok = {q_ctl.row_hi_ok, 1'b1, q_ctl.row_lo_ok};
   assign col_ok = {q_ctl.col_hi_ok, 1'b1, q_ctl.col_lo_ok};

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         row_sum[r] = (col_ok[0] ? ACC_BITS'(q_win[r*3])     : '0)
                    + ACC_BITS'(q_win[r*3 + 1])
                    + (col_ok[2] ? ACC_BITS'(q_win[r*3 + 2]) : '0);
      end
      acc = (row_ok[0] ? row_sum[0] : '0) + row_sum[1] + (row_ok[2] ? row_sum[2] : '0);
   end

   // Pick rounding offset and reciprocal from the neighbor count
   always_comb begin
      unique case ({row_ok[0] && row_ok[2], col_ok[0] && col_ok[2]})
         2'b11: begin
            round_add = ACC_BITS'(4);
            mag       = MAG_9;
         end
         2'b10, 2'b01: begin
            round_add = ACC_BITS'(3);
            mag       = MAG_6;
         end
         default: begin
            round_add = ACC_BITS'(2);
            mag       = MAG_4;
         end
      endcase
   end

   assign prod = b1_v_ff * b1_mag_ff;

   // Valid bits of the three stages
   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         b1_valid_ff  <= pop;
         b2_valid_ff  <= b1_valid_ff;
         rsp_valid_ff <= b2_valid_ff;
      end
   end

   // Sum, multiply by reciprocal, shift down
   always_ff @(posedge clock) begin
      if (advance) begin
         b1_v_ff    <= acc + round_add;
         b1_mag_ff  <= mag;
         b1_ctl_ff  <= q_ctl;
         b2_prod_ff <= prod;
         b2_ctl_ff  <= b1_ctl_ff;
         mean_ff    <= boxf_pkg::MEAN_BITS'(b2_prod_ff[SHIFT +: STORE_BITS]);
         x_ff       <= b2_ctl_ff.out_x;
         y_ff       <= b2_ctl_ff.out_y;
         last_ff    <= b2_ctl_ff.frame_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_mean   = mean_ff;
   assign rsp_x      = x_ff;
   assign rsp_y      = y_ff;
   assign rsp_last   = last_ff;

endmodule

[hdl/box_filter_3x3_mean_top.sv]
`timescale 1ns / 1ps
// 3x3 box mean filter for a raster-order pixel stream. Each result is the mean of the
// centre pixel and its neighbors that lie inside the frame (9 inside, 6 on an edge,
// 4 in a corner), rounded to nearest with halves going up. The result for a pixel is
// produced by the item that arrives frame_width + 1 items after it, so after the last
// pixel of a frame send frame_width + 1 drain items (tuser high) to flush the last row;
// drain items sent before the frame's pixels are complete are dropped. The block takes
// one item per clock while req_tready is high and gives at most one result per item. The
// result for an item passes the line store read, then the job queue and three back-end
// stages (neighbor sum, reciprocal multiply, result register). A four-entry job queue
// decouples the two halves; req_tready drops only when it fills while the result side
// stalls. Writing frame_width or frame_height restarts the frame and must be done only
// while the block is idle.
module box_filter_3x3_mean_top #(
   parameter int MAX_WIDTH  = 256,
   parameter int PIXEL_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Item in
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [15:0]                          req_tdata,   // pixel[15:0]
   input  logic                                 req_tuser,   // op: 0 pixel, 1 drain
   // Result out
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [39:0]                          rsp_tdata,   // mean[15:0], out_x[23:16],
                                                             // out_y[35:24], zero pad
   output logic                                 rsp_tlast,   // frame_end
   // Register write
   input  logic                                 csr_we,
   input  logic [boxf_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  logic [boxf_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int STORE_BITS = (PIXEL_BITS < boxf_pkg::PIXEL_IN_BITS) ?
                               PIXEL_BITS : boxf_pkg::PIXEL_IN_BITS;
   localparam int JOB_BITS   = $bits(boxf_pkg::job_ctl_type) + 9 * STORE_BITS;

   logic                                  push, pop, q_not_empty;
   logic [8:0][STORE_BITS-1:0]            push_win, head_win;
   boxf_pkg::job_ctl_type                 push_ctl, head_ctl;
   logic [JOB_BITS-1:0]                   head_data;
   logic [boxf_pkg::QUEUE_CNT_BITS-1:0]   q_count;
   logic [boxf_pkg::MEAN_BITS-1:0]        rsp_mean;
   logic [boxf_pkg::OUT_X_BITS-1:0]       rsp_x;
   logic [boxf_pkg::OUT_Y_BITS-1:0]       rsp_y;

   boxf_front #(.MAX_WIDTH(MAX_WIDTH), .STORE_BITS(STORE_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .q_count    (q_count),
      .push       (push),
      .push_win   (push_win),
      .push_ctl   (push_ctl)
   );

   boxf_queue #(.DATA_BITS(JOB_BITS)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_ctl, push_win}),
      .pop       (pop),
      .head_data (head_data),
      .not_empty (q_not_empty),
      .count     (q_count)
   );

   assign {head_ctl, head_win} = head_data;

   boxf_back #(.STORE_BITS(STORE_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_not_empty),
      .q_win      (head_win),
      .q_ctl      (head_ctl),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_mean   (rsp_mean),
      .rsp_x      (rsp_x),
      .rsp_y      (rsp_y),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {4'b0000, rsp_y, rsp_x, rsp_mean};

endmodule

[hdl/boxf_checker.sv]
`timescale 1ns / 1ps
module boxf_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic [15:0]                          req_tdata,
   input logic                                 req_tuser,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [39:0]                          rsp_tdata,
   input logic                                 rsp_tlast,
   input logic                                 csr_we,
   input logic [boxf_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input logic [boxf_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   logic rsp_fire;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // No result right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A frame has at least two rows, so its last pixel is never on row zero
   a_end_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[35:24] != 12'd0)
      else $error("frame end on row zero");

   // Back-to-back results in a frame stay on the row, step to the next one or restart at row zero
   a_row_step: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && $past(rsp_fire) && !$past(rsp_tlast) && !$past(reset)
      |-> (rsp_tdata[35:24] == $past(rsp_tdata[35:24]))
       || (rsp_tdata[35:24] == $past(rsp_tdata[35:24]) + 12'd1)
       || (rsp_tdata[35:24] == 12'd0))
      else $error("output row skipped");

endmodule

bind box_filter_3x3_mean_top boxf_checker u_checker (.*);
